// ===== src/mdf_pkg.sv =====
`default_nettype none
package mdf_pkg;
	localparam int MOD_WIDTH = 32;
	localparam int IN_WIDTH  = 64;
	localparam int CNT_W     = $clog2(IN_WIDTH);
	localparam int ECNT_W    = $clog2(MOD_WIDTH);
	localparam logic [MOD_WIDTH-1:0] P_MIN = MOD_WIDTH'(2);
	localparam logic [MOD_WIDTH-1:0] ONE   = MOD_WIDTH'(1);
endpackage
`default_nettype wire

// ===== src/modular_division_fermat.sv =====
`default_nettype none
// Computes (dividend / divisor) mod p, with the divisor inverted as divisor^(p-2).
// Hold start high while busy is low to hand over a beat. Each operand is reduced
// bit-serially, the divisor first and then the dividend, and a divisor that
// reduces to zero finishes there. Otherwise 32 exponent bits follow, each taking
// a setup step, a square and, for every set bit of p-2, a multiply. One final
// multiply then gives the quotient. All of this runs on one shared double-and-add
// modular unit that retires one bit per cycle. The result shows for one cycle with
// done high and must be captured then; there is no way to hold it. no_inverse flags
// a divisor that reduces to zero, with quotient 0. The modulus is taken only while
// idle with start low.
module modular_division_fermat (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [mdf_pkg::IN_WIDTH-1:0]  dividend,
	input  wire logic [mdf_pkg::IN_WIDTH-1:0]  divisor,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [31:0]                   cfg_data,
	output logic                               done,
	output logic [31:0]                        quotient,
	output logic                               no_inverse
);
	import mdf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RED_B, S_RED_A, S_EXP, S_MUL_ACC, S_MUL_SQ, S_MUL_Q
	} state_t;

	state_t                 state_q;
	logic [MOD_WIDTH-1:0]   modulus_q;
	logic [IN_WIDTH-1:0]    sh_q;
	logic [IN_WIDTH-1:0]    dividend_q;
	logic [MOD_WIDTH-1:0]   r_q, mcand_q, sq_q, acc_q, a_q, e_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [ECNT_W-1:0]      ecnt_q;
	logic                   done_q, noinv_q;
	logic [MOD_WIDTH-1:0]   quot_q;

	logic [MOD_WIDTH-1:0]   p;
	logic [MOD_WIDTH:0]     dbl, sum;
	logic [MOD_WIDTH-1:0]   dbl_red, addend, res;
	logic                   reducing, last_red, last_mul;

	assign p = (modulus_q < P_MIN) ? P_MIN : modulus_q;

	// Shared unit: res = (2*r + addend) mod p, both operands already below p.
	assign reducing = (state_q == S_RED_B) || (state_q == S_RED_A);
	assign addend   = reducing ? {{(MOD_WIDTH-1){1'b0}}, sh_q[IN_WIDTH-1]}
	                           : (sh_q[IN_WIDTH-1] ? mcand_q : '0);
	assign dbl      = {r_q, 1'b0};
	assign dbl_red  = (dbl >= {1'b0, p}) ? MOD_WIDTH'(dbl - {1'b0, p}) : dbl[MOD_WIDTH-1:0];
	assign sum      = {1'b0, dbl_red} + {1'b0, addend};
	assign res      = (sum >= {1'b0, p}) ? MOD_WIDTH'(sum - {1'b0, p}) : sum[MOD_WIDTH-1:0];

	assign last_red = (cnt_q == CNT_W'(IN_WIDTH-1));
	assign last_mul = (cnt_q == CNT_W'(MOD_WIDTH-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			modulus_q  <= P_MIN;
			done_q     <= 1'b0;
			noinv_q    <= 1'b0;
			quot_q     <= '0;
			sh_q       <= '0;
			dividend_q <= '0;
			r_q        <= '0;
			mcand_q    <= '0;
			sq_q       <= '0;
			acc_q      <= '0;
			a_q        <= '0;
			e_q        <= '0;
			cnt_q      <= '0;
			ecnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				modulus_q <= cfg_data[MOD_WIDTH-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						sh_q       <= divisor;
						dividend_q <= dividend;
						r_q        <= '0;
						cnt_q      <= '0;
						state_q    <= S_RED_B;
					end
				end
				S_RED_B: begin
					r_q   <= res;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_red) begin
						sq_q    <= res;
						r_q     <= '0;
						sh_q    <= dividend_q;
						cnt_q   <= '0;
						state_q <= S_RED_A;
					end
				end
				S_RED_A: begin
					r_q   <= res;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_red) begin
						a_q <= res;
						if (sq_q == '0) begin
							quot_q  <= '0;
							noinv_q <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							acc_q   <= ONE;
							e_q     <= p - P_MIN;
							ecnt_q  <= '0;
							state_q <= S_EXP;
						end
					end
				end
				S_EXP: begin
					r_q     <= '0;
					cnt_q   <= '0;
					mcand_q <= sq_q;
					if (e_q[0]) begin
						sh_q    <= {acc_q, {(IN_WIDTH-MOD_WIDTH){1'b0}}};
						state_q <= S_MUL_ACC;
					end else begin
						sh_q    <= {sq_q, {(IN_WIDTH-MOD_WIDTH){1'b0}}};
						state_q <= S_MUL_SQ;
					end
				end
				S_MUL_ACC: begin
					r_q   <= res;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_mul) begin
						acc_q   <= res;
						r_q     <= '0;
						cnt_q   <= '0;
						sh_q    <= {sq_q, {(IN_WIDTH-MOD_WIDTH){1'b0}}};
						state_q <= S_MUL_SQ;
					end
				end
				S_MUL_SQ: begin
					r_q   <= res;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_mul) begin
						sq_q   <= res;
						e_q    <= e_q >> 1;
						ecnt_q <= ecnt_q + ECNT_W'(1);
						if (ecnt_q == ECNT_W'(MOD_WIDTH-1)) begin
							r_q     <= '0;
							cnt_q   <= '0;
							mcand_q <= a_q;
							sh_q    <= {acc_q, {(IN_WIDTH-MOD_WIDTH){1'b0}}};
							state_q <= S_MUL_Q;
						end else begin
							state_q <= S_EXP;
						end
					end
				end
				S_MUL_Q: begin
					r_q   <= res;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_mul) begin
						quot_q  <= res;
						noinv_q <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	// A new modulus must never land under a beat that is being taken or worked on.
	assign cfg_ready  = !busy && !start;
	assign done       = done_q;
	assign quotient   = 32'(quot_q);
	assign no_inverse = noinv_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat lasted more than one cycle");
	a_noinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && no_inverse) |-> (quotient == '0)) else $error("nonzero quotient with no inverse");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not start work");
endmodule
`default_nettype wire

// ===== tb/sv/mdf_checker.sv =====
`default_nettype none
module mdf_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire logic        done,
	input  wire logic [31:0] quotient,
	input  wire logic        no_inverse,
	output int               errors,
	output int               pending,
	output int               quotients_seen,
	output int               zero_divisors_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] quot;
		logic        noinv;
	} quot_t;

	logic [mdf_pkg::MOD_WIDTH-1:0] mod_reg;
	quot_t                         quot_q[$];

	function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		return (x * y) % m;
	endfunction

	function automatic quot_t divide_mod(logic [63:0] num, logic [63:0] den);
		logic [63:0] m;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] prod;
		quot_t       r;
		m = {32'd0, mod_reg};
		if (m < 64'd2)
			m = 64'd2;
		a = num % m;
		b = den % m;
		r.quot = '0;
		r.noinv = 1'b0;
		if (b == 64'd0) begin
			r.noinv = 1'b1;
			return r;
		end
		acc = 64'd1 % m;
		sq = b;
		e = m - 64'd2;
		while (e != 64'd0) begin
			if (e[0])
				acc = mul_mod(acc, sq, m);
			e = e >> 1;
			sq = mul_mod(sq, sq, m);
		end
		prod = mul_mod(a, acc, m);
		r.quot = prod[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		quot_t want;
		if (!arst_n) begin
			mod_reg <= mdf_pkg::P_MIN;
			errors = 0;
			quotients_seen = 0;
			zero_divisors_seen = 0;
			quot_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				mod_reg <= cfg_data[mdf_pkg::MOD_WIDTH-1:0];
			if (start && !busy)
				quot_q.push_back(divide_mod(dividend, divisor));
			if (done) begin
				quotients_seen++;
				if (no_inverse)
					zero_divisors_seen++;
				if (quot_q.size() == 0)
					report_mismatch("unexpected beat", quotient, 32'd0);
				else begin
					want = quot_q.pop_front();
					if (quotient !== want.quot)
						report_mismatch("quotient", quotient, want.quot);
					if (no_inverse !== want.noinv)
						report_mismatch("no_inverse", 32'(no_inverse), 32'(want.noinv));
				end
			end
		end
	end

	assign pending = quot_q.size();
endmodule
`default_nettype wire

// ===== tb/sv/tb_modular_division_fermat.sv =====
`default_nettype none
module tb_modular_division_fermat;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] dividend = '0;
	logic [63:0] divisor = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        done;
	logic [31:0] quotient;
	logic        no_inverse;
	int          errors;
	int          pending;
	int          quotients_seen;
	int          zero_divisors_seen;
	int          idle_cycles = 0;
	logic [31:0] cur_mod = 32'd2;

	always #4 clk = ~clk;

	modular_division_fermat u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.dividend(dividend), .divisor(divisor),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .quotient(quotient), .no_inverse(no_inverse)
	);

	mdf_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.dividend(dividend), .divisor(divisor),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .quotient(quotient), .no_inverse(no_inverse),
		.errors(errors), .pending(pending),
		.quotients_seen(quotients_seen), .zero_divisors_seen(zero_divisors_seen)
	);

	// Any accepted beat, modulus write or finished result counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Timeout: no progress for %0d cycles", WATCHDOG);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Handshake inputs only change at rising edges, so they are looked at on the
	// falling edge to know whether the next rising edge takes the beat.
	task automatic write_modulus(logic [31:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		cur_mod = value;
	endtask

	task automatic divide(logic [63:0] num, logic [63:0] den);
		repeat ($urandom_range(0, 8) * ($urandom_range(0, 3) != 0)) @(posedge clk);
		dividend <= num;
		divisor <= den;
		start <= 1'b1;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		start <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Mostly small multiples of the modulus plus offsets, so zero divisors occur often.
	function automatic logic [63:0] pick_operand();
		logic [63:0] m;
		m = (cur_mod < 2) ? 64'd2 : {32'd0, cur_mod};
		case ($urandom_range(0, 5))
			0: return m * $urandom_range(0, 7);
			1: return {$urandom, $urandom};
			2: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
			default: return m * $urandom_range(0, 1000) + $urandom_range(0, 3);
		endcase
	endfunction

	initial begin
		logic [31:0] mods[8];
		int          phase;
		int          k;
		mods = '{32'd0, 32'd2, 32'd7, 32'd1, 32'd65521, 32'd4294967291, 32'd4294967295, 32'd12};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Default modulus of two first, then the extremes of the register.
		divide(64'd0, 64'd0);
		divide(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		divide(64'd5, 64'd3);
		drain();
		write_modulus(32'd4294967291);
		divide(64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
		divide(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		divide(64'd0, 64'd4294967291);
		divide(64'd12345, 64'd4294967290);
		divide(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		drain();
		write_modulus(32'd1);
		divide(64'd9, 64'd3);
		divide(64'd9, 64'd4);
		drain();
		write_modulus(32'd0);
		divide(64'd7, 64'd7);
		drain();
		write_modulus(32'd15);
		divide(64'd7, 64'd3);
		divide(64'd7, 64'd4);
		divide(64'd14, 64'd30);
		drain();
		for (phase = 0; phase < 8; phase++) begin
			write_modulus((phase == 7) ? $urandom : mods[phase]);
			for (k = 0; k < 15; k++)
				divide(pick_operand(), pick_operand());
			drain();
		end
		$display("Covered %0d divisions, %0d with a divisor of zero modulo p,",
			quotients_seen, zero_divisors_seen);
		$display("across moduli from 0 up to the 32-bit maximum, prime and composite.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/mdf_pkg.sv
src/modular_division_fermat.sv
tb/sv/mdf_checker.sv
tb/sv/tb_modular_division_fermat.sv
